FILE: rtl/blg_pkg.sv
package blg_pkg;

    // Default moving average window (newest sample plus the delay line)
    localparam int WINDOW_LENGTH_DEF = 10;

    // Fixed scaling constants
    localparam int ADC_FULL_SCALE = 4095;
    localparam int ADC_REF_MV     = 3300;
    localparam int RESET_EMPTY_MV = 3300;
    localparam int RESET_FULL_MV  = 3900;
    localparam int PERCENT_FULL   = 100;

    // Field widths
    localparam int ADC_W = 12;
    localparam int MV_W  = 13;
    localparam int PCT_W = 7;

    // Millivolt scale as (avg * MV_MUL) >> MV_SHIFT: MV_MUL is 3300/4095 rounded
    // up, and 4095 * 4095 < 2^MV_SHIFT keeps the quotient exact for any 12-bit
    // average
    localparam int     MV_SHIFT = 24;
    localparam longint MV_MUL   =
        ((longint'(ADC_REF_MV) << MV_SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;

    // Percent divider operand widths: dividend covers (mv - empty) * 100 (< 2^20)
    localparam int DVD_W = 20;
    localparam int DVS_W = 13;

    // Configuration port
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_MV = 1'b0,
        CFG_FULL_MV  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             charge_pin;
        logic             usb_pin;
    } t_req;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic [MV_W-1:0]  millivolts;
        logic             charging;
        logic             external_power;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_AVG     = 3'd1,
        S_MV      = 3'd2,
        S_SCALE   = 3'd3,
        S_PCT_GO  = 3'd4,
        S_PCT_RUN = 3'd5,
        S_DONE    = 3'd6
    } t_state;

    typedef struct packed {
        logic capture;
        logic take_avg;
        logic take_mv;
        logic take_scale;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/battery_level_gauge_core.sv
// Battery level gauge: each request carries a 12-bit ADC sample and the charge
// and external-power pin levels; the block averages it with the previous
// WINDOW_LENGTH-1 samples, scales to millivolts (x3300/4095, doubled for the
// divider), clamps to the empty/full registers and maps the result to 0..100
// percent, with charging set when not full and the charge pin is low. One
// request is processed at a time. After acceptance the controller steps
// through the window average and the millivolt scale (both reciprocal
// multiplies), forms the percent dividend, starts the divider, waits for the
// divider that retires two quotient bits per cycle over a 20-bit dividend,
// and hands the quotient to the output register once that register is free.
// A new request is accepted from the cycle after the result is loaded. The
// result waits in an output register, so the next request is accepted while
// the previous result is still pending; a second result then waits for the
// first to be taken. The window sum is kept as a running total, so the
// window length does not change the latency. Configuration writes (index 0
// empty, index 1 full) take effect at once and belong in idle periods.
module battery_level_gauge_core #(
    parameter int WINDOW_LENGTH = blg_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [blg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blg_pkg::MV_W-1:0]      i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  blg_pkg::t_req                 i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output blg_pkg::t_res                 o_res
);

    blg_pkg::t_cmd    w_cmd;
    blg_pkg::t_status w_status;

    blg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    blg_dp #(
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res)
    );

    // A pending result never reports more than full
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.percent <= blg_pkg::PCT_W'(blg_pkg::PERCENT_FULL)))
        else $error("percent above full scale");

    // Charging is never reported at full charge
    a_chg_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.charging) |->
        (o_res.percent != blg_pkg::PCT_W'(blg_pkg::PERCENT_FULL)))
        else $error("charging flagged at full charge");

    // One request at a time: ready drops after an accepted request
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

endmodule

FILE: rtl/blg_div.sv
module blg_div #(
    parameter int DVD_W = blg_pkg::DVD_W,
    parameter int DVS_W = blg_pkg::DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    // Two quotient bits retire per cycle
    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   n_rem;
    logic [DVD_W-1:0] n_quo;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[DVS_W-1:0], n_quo[DVD_W-1]};
            n_quo = {n_quo[DVD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    // Track run and completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/blg_ctrl.sv
module blg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  blg_pkg::t_status i_status,
    output blg_pkg::t_cmd    o_cmd
);

    blg_pkg::t_state r_state;
    blg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through average, scale, percent division and hand-off
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blg_pkg::S_IDLE: begin
                if (i_valid) n_state = blg_pkg::S_AVG;
            end
            blg_pkg::S_AVG:     n_state = blg_pkg::S_MV;
            blg_pkg::S_MV:      n_state = blg_pkg::S_SCALE;
            blg_pkg::S_SCALE:   n_state = blg_pkg::S_PCT_GO;
            blg_pkg::S_PCT_GO:  n_state = blg_pkg::S_PCT_RUN;
            blg_pkg::S_PCT_RUN: begin
                if (i_status.div_done) n_state = blg_pkg::S_DONE;
            end
            blg_pkg::S_DONE: begin
                if (i_status.out_free) n_state = blg_pkg::S_IDLE;
            end
            default: n_state = blg_pkg::S_IDLE;
        endcase
    end

    // Issue datapath commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            blg_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            blg_pkg::S_AVG:     o_cmd.take_avg   = 1'b1;
            blg_pkg::S_MV:      o_cmd.take_mv    = 1'b1;
            blg_pkg::S_SCALE:   o_cmd.take_scale = 1'b1;
            blg_pkg::S_PCT_GO:  o_cmd.div_start  = 1'b1;
            blg_pkg::S_PCT_RUN: ;
            blg_pkg::S_DONE:    o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/blg_dp.sv
module blg_dp #(
    parameter int WINDOW_LENGTH = blg_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [blg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [blg_pkg::MV_W-1:0]       i_cfg_data,
    input  blg_pkg::t_req                  i_req,
    input  blg_pkg::t_cmd                  i_cmd,
    output blg_pkg::t_status               o_status,
    output logic                           o_valid,
    input  logic                           i_ready,
    output blg_pkg::t_res                  o_res
);

    localparam int DEPTH = WINDOW_LENGTH - 1;
    localparam int SUM_W = $clog2(WINDOW_LENGTH * blg_pkg::ADC_FULL_SCALE + 1);
    localparam int ADC_W = blg_pkg::ADC_W;
    localparam int MV_W  = blg_pkg::MV_W;
    localparam int PCT_W = blg_pkg::PCT_W;
    localparam int DVD_W = blg_pkg::DVD_W;
    localparam int DVS_W = blg_pkg::DVS_W;

    // Window average as (sum * AVG_MUL) >> AVG_SHIFT; AVG_MUL is the reciprocal
    // rounded up, exact for every sum below 2^SUM_W
    localparam int     AVG_SHIFT  = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int     AVG_PROD_W = 2 * SUM_W + 1;
    localparam longint AVG_MUL    =
        ((longint'(1) << AVG_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int     MV_PROD_W  = ADC_W + blg_pkg::MV_SHIFT;

    logic [ADC_W-1:0] r_hist [DEPTH];
    logic [SUM_W-1:0] r_hist_sum;
    logic [SUM_W-1:0] r_sum;
    logic             r_chg;
    logic             r_usb;
    logic [MV_W-1:0]  r_empty;
    logic [MV_W-1:0]  r_full;
    logic [ADC_W-1:0] r_avg;
    logic [DVD_W-1:0] r_prod;
    logic [MV_W-1:0]  r_mv;
    logic             r_out_valid;
    blg_pkg::t_res    r_out;

    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [MV_PROD_W-1:0]  w_mv_prod;
    logic [DVS_W-1:0]      w_divisor;
    logic                  w_div_done;
    logic [DVD_W-1:0]      w_quo;
    logic [MV_W-1:0]       w_mv_raw;
    logic [MV_W-1:0]       w_mv_clamp;
    logic                  w_range_ok;
    logic [PCT_W-1:0]      w_pct;

    // Configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= MV_W'(blg_pkg::RESET_EMPTY_MV);
            r_full  <= MV_W'(blg_pkg::RESET_FULL_MV);
        end else if (i_cfg_we) begin
            unique case (blg_pkg::t_cfg_idx'(i_cfg_index))
                blg_pkg::CFG_EMPTY_MV: r_empty <= i_cfg_data;
                blg_pkg::CFG_FULL_MV:  r_full  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Delay line and its running sum: drop the oldest, add the newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_hist[0]  <= ADC_W'(blg_pkg::ADC_FULL_SCALE);
            r_hist_sum <= SUM_W'(blg_pkg::ADC_FULL_SCALE);
        end else if (i_cmd.capture) begin
            for (int k = DEPTH - 1; k > 0; k--) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_hist[0]  <= i_req.adc_sample;
            r_hist_sum <= r_hist_sum + SUM_W'(i_req.adc_sample)
                          - SUM_W'(r_hist[DEPTH-1]);
        end
    end

    // Latch the window sum and the pins of the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sum <= r_hist_sum + SUM_W'(i_req.adc_sample);
            r_chg <= i_req.charge_pin;
            r_usb <= i_req.usb_pin;
        end
    end

    // Reciprocal products for the average and the millivolt scale
    assign w_avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_MUL);
    assign w_mv_prod  = MV_PROD_W'(r_avg) * MV_PROD_W'(blg_pkg::MV_MUL);

    // Double the scaled voltage and clamp to the bounds, lower bound first
    assign w_mv_raw = {w_mv_prod[blg_pkg::MV_SHIFT +: MV_W-1], 1'b0};
    always_comb begin
        if (w_mv_raw < r_empty) begin
            w_mv_clamp = r_empty;
        end else if (w_mv_raw > r_full) begin
            w_mv_clamp = r_full;
        end else begin
            w_mv_clamp = w_mv_raw;
        end
    end

    // Average, clamped voltage and percent dividend, one step per state
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_avg) begin
            r_avg <= w_avg_prod[AVG_SHIFT +: ADC_W];
        end
        if (i_cmd.take_mv) begin
            r_mv <= w_mv_clamp;
        end
        if (i_cmd.take_scale) begin
            r_prod <= DVD_W'((r_mv - r_empty) * DVD_W'(blg_pkg::PERCENT_FULL));
        end
    end

    assign w_divisor = r_full - r_empty;

    blg_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // An empty or inverted range reports zero percent
    assign w_range_ok = (r_full > r_empty);
    assign w_pct      = w_range_ok ? w_quo[PCT_W-1:0] : '0;

    // Output register: hold until the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.percent        <= w_pct;
            r_out.millivolts     <= r_mv;
            r_out.charging       <= (w_pct != PCT_W'(blg_pkg::PERCENT_FULL)) && !r_chg;
            r_out.external_power <= r_usb;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_res             = r_out;

endmodule

FILE: tb/battery_level_gauge_core_checker.sv
`timescale 1ns / 1ps

module battery_level_gauge_core_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [blg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blg_pkg::MV_W-1:0]      i_cfg_data,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  blg_pkg::t_req                 i_req,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  blg_pkg::t_res                 i_res,
    output int                            o_mismatches,
    output int                            o_pending
);
    import blg_pkg::*;

    localparam int HISTORY_DEPTH = WINDOW_LENGTH_DEF - 1;
    localparam int MAX_REPORTS   = 10;

    // Shadow copy of the delay line and the two voltage limits
    logic [ADC_W-1:0] sample_line [HISTORY_DEPTH];
    logic [MV_W-1:0]  empty_mv;
    logic [MV_W-1:0]  full_mv;

    t_res expected_gauge_q [$];
    int   mismatches = 0;

    // Average the request with the delay line, scale, clamp and map to percent;
    // then advance the delay line
    function automatic t_res gauge_step(input t_req rq);
        int unsigned sum;
        int unsigned avg;
        int unsigned mv;
        int unsigned pct;
        t_res        res;
        sum = 32'(rq.adc_sample);
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            sum += 32'(sample_line[k]);
        end
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            sample_line[k] = sample_line[k-1];
        end
        sample_line[0] = rq.adc_sample;

        avg = sum / WINDOW_LENGTH_DEF;
        mv  = (avg * ADC_REF_MV / ADC_FULL_SCALE) * 2;

        // Lower clamp wins over the upper one
        if (mv < 32'(empty_mv)) begin
            mv = 32'(empty_mv);
        end else if (mv > 32'(full_mv)) begin
            mv = 32'(full_mv);
        end

        // An empty or inverted range reads as zero percent
        if (full_mv > empty_mv) begin
            pct = (mv - 32'(empty_mv)) * PERCENT_FULL / (32'(full_mv) - 32'(empty_mv));
        end else begin
            pct = 0;
        end

        res.percent        = pct[PCT_W-1:0];
        res.millivolts     = mv[MV_W-1:0];
        res.charging       = (pct != PERCENT_FULL) && !rq.charge_pin;
        res.external_power = rq.usb_pin;
        return res;
    endfunction

    task automatic report_failure(input string why, input t_res want, input t_res got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display({"%0t %s: expected pct=%0d mv=%0d chg=%0b ext=%0b,",
                      " got pct=%0d mv=%0d chg=%0b ext=%0b"},
                     $time, why, want.percent, want.millivolts, want.charging,
                     want.external_power, got.percent, got.millivolts, got.charging,
                     got.external_power);
        end
    endtask

    // Track configuration, predict each accepted request, compare each result
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                sample_line[k] = '0;
            end
            sample_line[0] = ADC_W'(ADC_FULL_SCALE);
            empty_mv       = MV_W'(RESET_EMPTY_MV);
            full_mv        = MV_W'(RESET_FULL_MV);
            expected_gauge_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_EMPTY_MV: empty_mv = i_cfg_data;
                    CFG_FULL_MV:  full_mv  = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (expected_gauge_q.size() == 0) begin
                    report_failure("unexpected result", '0, i_res);
                end else begin
                    want = expected_gauge_q.pop_front();
                    if (want.percent !== i_res.percent ||
                        want.millivolts !== i_res.millivolts ||
                        want.charging !== i_res.charging ||
                        want.external_power !== i_res.external_power) begin
                        report_failure("result mismatch", want, i_res);
                    end
                end
            end

            if (i_req_valid && i_req_ready) begin
                expected_gauge_q.push_back(gauge_step(i_req));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_gauge_q.size();
    end

endmodule

FILE: tb/battery_level_gauge_core_test.sv
`timescale 1ns / 1ps

module battery_level_gauge_core_test;
    import blg_pkg::*;

    localparam int RESET_CYCLES     = 5;
    localparam int SEGMENT_COUNT    = 8;
    localparam int SEGMENT_REQUESTS = 190;
    localparam int RX_HOLD_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 60;
    localparam int MAX_MV           = 6600;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    t_cfg_idx           i_cfg_index = CFG_EMPTY_MV;
    logic [MV_W-1:0]    i_cfg_data  = '0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    t_req               i_req       = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    t_res               o_res;

    int          mismatches;
    int          pending;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    bit          rx_hold_req  = 1'b0;
    int          quiet_cycles = 0;
    int unsigned adc_level    = 2048;

    battery_level_gauge_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res)
    );

    battery_level_gauge_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_res),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // Result side: random backpressure, plus one long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("battery_level_gauge_core verification failed");
            $finish;
        end
    end

    // Offer one request after a random gap; hold it until accepted
    task automatic send_request(input t_req rq);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_requests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write both voltage limits on back-to-back cycles
    task automatic set_limits(input int empty_mv, input int full_mv);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EMPTY_MV;
        i_cfg_data  <= MV_W'(empty_mv);
        @(posedge i_clk);
        i_cfg_index <= CFG_FULL_MV;
        i_cfg_data  <= MV_W'(full_mv);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Often wander around a slowly moving level so the average sweeps the
    // whole range; mix in rails and uniform noise
    function automatic t_req random_request();
        t_req rq;
        int   lvl;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                lvl = int'(adc_level) + int'($urandom_range(0, 128)) - 64;
                if (lvl < 0) lvl = 0;
                if (lvl > ADC_FULL_SCALE) lvl = ADC_FULL_SCALE;
                adc_level     = lvl;
                rq.adc_sample = ADC_W'(lvl);
            end
            4: begin
                adc_level     = $urandom_range(0, ADC_FULL_SCALE);
                rq.adc_sample = ADC_W'(adc_level);
            end
            5:       rq.adc_sample = '0;
            6:       rq.adc_sample = ADC_W'(ADC_FULL_SCALE);
            default: rq.adc_sample = ADC_W'($urandom_range(0, ADC_FULL_SCALE));
        endcase
        rq.charge_pin = 1'($urandom_range(0, 1));
        rq.usb_pin    = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    initial begin
        int lo;
        int hi;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limits: fill the delay line with full scale, walk all pin levels;
        // the last ones read 100 percent and must not report charging
        for (int i = 0; i < 10; i++) begin
            send_request('{adc_sample: ADC_W'(ADC_FULL_SCALE), charge_pin: i[0], usb_pin: i[1]});
        end
        drain_requests();

        // Full below empty: a high voltage reports the upper bound
        set_limits(5000, 1000);
        send_request('{adc_sample: ADC_W'(ADC_FULL_SCALE), charge_pin: 1'b0, usb_pin: 1'b0});
        send_request('{adc_sample: ADC_W'(ADC_FULL_SCALE), charge_pin: 1'b1, usb_pin: 1'b1});
        drain_requests();

        // Widest range: top of scale, then decay toward zero
        set_limits(0, MAX_MV);
        send_request('{adc_sample: ADC_W'(ADC_FULL_SCALE), charge_pin: 1'b0, usb_pin: 1'b1});
        send_request('{adc_sample: ADC_W'(ADC_FULL_SCALE), charge_pin: 1'b1, usb_pin: 1'b0});
        for (int i = 0; i < 4; i++) begin
            send_request('{adc_sample: '0, charge_pin: i[0], usb_pin: i[1]});
        end
        drain_requests();

        // Equal limits: empty range, charging follows the pin alone
        set_limits(4000, 4000);
        send_request('{adc_sample: '0, charge_pin: 1'b0, usb_pin: 1'b0});
        send_request('{adc_sample: '0, charge_pin: 1'b1, usb_pin: 1'b1});
        drain_requests();

        // Random segments, each with its own limits and idling profile
        for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
            if (seg < 3) begin
                tx_idle_pct = 8;
                rx_idle_pct = 73;
            end else if (seg < 6) begin
                tx_idle_pct = 73;
                rx_idle_pct = 8;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            lo = $urandom_range(0, MAX_MV);
            hi = $urandom_range(0, MAX_MV);
            case (seg)
                0: set_limits(0, MAX_MV);
                2: set_limits(MAX_MV, MAX_MV);
                3: set_limits(lo % 4000 + 1000, lo % 4000 + 1000 + $urandom_range(1, 600));
                4: set_limits(lo, hi);
                5: set_limits(MAX_MV, 0);
                7: set_limits(0, 0);
                default: set_limits(lo < hi ? lo : hi, lo < hi ? hi : lo);
            endcase

            // Let the input back up behind a stalled result side
            if (seg == 6) rx_hold_req = 1'b1;

            repeat (SEGMENT_REQUESTS) send_request(random_request());
            drain_requests();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("battery_level_gauge_core verification clean");
        end else begin
            $display("battery_level_gauge_core verification failed");
        end
        $finish;
    end

endmodule
